// ===== src/ille_pkg.sv =====
// ----------------------------------------------------------------------------
// ille_pkg
// Shared sizes, request and status codes, the control word layout and the
// control store for the indexed linked list engine.
// ----------------------------------------------------------------------------
package ille_pkg;

   localparam int CAPACITY = 64;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY) + 1;
   localparam int VALUE_W  = 64;
   localparam int TYPE_W   = 4;
   localparam int STATUS_W = 2;

   typedef enum logic [TYPE_W-1:0] {
      REQ_PUSH_AFTER  = 4'd0,
      REQ_PUSH_BEFORE = 4'd1,
      REQ_PUSH_FRONT  = 4'd2,
      REQ_PUSH_BACK   = 4'd3,
      REQ_POP_AFTER   = 4'd4,
      REQ_POP_BEFORE  = 4'd5,
      REQ_POP_FRONT   = 4'd6,
      REQ_POP_BACK    = 4'd7,
      REQ_LOCATE      = 4'd8
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_BAD   = 2'd3
   } status_type;

   // one entry of the forward link table: in-use flag and next slot
   typedef struct packed {
      logic              used;
      logic [SLOT_W-1:0] link;
   } link_word_type;

   // microcode addresses
   typedef enum logic [4:0] {
      S_PSA, S_PSB, S_PSF, S_PSK, S_PSK2,
      S_LK0, S_LK1, S_LK2, S_LK3, S_LK4,
      S_PAF, S_PBF, S_PBF2, S_PBF3, S_PF, S_PK, S_PK2,
      S_UL0, S_UL1, S_UL2, S_UL3, S_UL4,
      S_LOC0, S_LOC1, S_LOCEND,
      S_BAD, S_EMPTY, S_FULL
   } step_type;

   // forward link table read address
   typedef enum logic [2:0] {
      NRA_NONE, NRA_ZERO, NRA_FTOP, NRA_ANC, NRA_LINK
   } nra_type;

   // backward link table read address
   typedef enum logic [1:0] {
      PRA_NONE, PRA_ZERO, PRA_D
   } pra_type;

   // forward link table write
   typedef enum logic [2:0] {
      WN_NONE, WN_PUSH_A, WN_ANC_A, WN_ANC_N, WN_FREE_D
   } wn_type;

   // backward link table write
   typedef enum logic [2:0] {
      WP_NONE, WP_A_ANC, WP_N_A, WP_N_ANC, WP_D_ZERO
   } wp_type;

   // register transfers
   typedef enum logic [3:0] {
      ACT_NONE, ACT_ANC_TGT, ACT_ANC_ZERO, ACT_ANC_PLINK, ACT_A_FTOP,
      ACT_FTOP_LINK, ACT_N_AU, ACT_D_AU, ACT_N, ACT_D_ZERO, ACT_D_PLINK,
      ACT_HOP, ACT_PUSH_DONE, ACT_POP_DONE
   } act_type;

   // jump conditions
   typedef enum logic [2:0] {
      C_NONE, C_NOUSE, C_FULL, C_POPNONE, C_DZERO, C_TGTZERO, C_TGTNOTONE
   } cond_type;

   // result produced by a final step
   typedef enum logic [2:0] {
      RES_NONE, RES_BAD, RES_FULL, RES_EMPTY, RES_PUSH, RES_POP, RES_LOC
   } res_type;

   typedef struct packed {
      nra_type  nra;
      pra_type  pra;
      logic     vrd;
      logic     vwr;
      wn_type   wn;
      wp_type   wp;
      act_type  act;
      cond_type cond;
      step_type jmp;
      step_type nxt;
      res_type  res;
   } ctrl_word_type;

   // reset contents of a forward link entry: sentinel loops, free chain ascends
   function automatic link_word_type link_reset(logic [SLOT_W-1:0] addr);
      link_word_type w;
      w.used = (addr == '0);
      if (addr == '0 || addr == SLOT_W'(CAPACITY - 1)) begin
         w.link = '0;
      end else begin
         w.link = addr + SLOT_W'(1);
      end
      return w;
   endfunction

   // first step of each request type
   function automatic step_type dispatch(logic [TYPE_W-1:0] code);
      step_type s;
      case (code)
         REQ_PUSH_AFTER:  s = S_PSA;
         REQ_PUSH_BEFORE: s = S_PSB;
         REQ_PUSH_FRONT:  s = S_PSF;
         REQ_PUSH_BACK:   s = S_PSK;
         REQ_POP_AFTER:   s = S_PAF;
         REQ_POP_BEFORE:  s = S_PBF;
         REQ_POP_FRONT:   s = S_PF;
         REQ_POP_BACK:    s = S_PK;
         REQ_LOCATE:      s = S_LOC0;
         default:         s = S_BAD;
      endcase
      return s;
   endfunction

   // control store
   function automatic ctrl_word_type ucode(step_type s);
      ctrl_word_type cw;
      cw.nra  = NRA_NONE;
      cw.pra  = PRA_NONE;
      cw.vrd  = 1'b0;
      cw.vwr  = 1'b0;
      cw.wn   = WN_NONE;
      cw.wp   = WP_NONE;
      cw.act  = ACT_NONE;
      cw.cond = C_NONE;
      cw.jmp  = S_BAD;
      cw.nxt  = S_BAD;
      cw.res  = RES_NONE;
      case (s)
         // push entry points: settle the anchor
         S_PSA: begin
            cw.cond = C_NOUSE; cw.jmp = S_BAD; cw.act = ACT_ANC_TGT; cw.nxt = S_LK0;
         end
         S_PSB: begin
            cw.cond = C_NOUSE; cw.jmp = S_BAD; cw.act = ACT_ANC_PLINK; cw.nxt = S_LK0;
         end
         S_PSF: begin
            cw.act = ACT_ANC_ZERO; cw.nxt = S_LK0;
         end
         S_PSK: begin
            cw.pra = PRA_ZERO; cw.nxt = S_PSK2;
         end
         S_PSK2: begin
            cw.act = ACT_ANC_PLINK; cw.nxt = S_LK0;
         end
         // link a free slot in after the anchor
         S_LK0: begin
            cw.cond = C_FULL; cw.jmp = S_FULL;
            cw.nra = NRA_FTOP; cw.act = ACT_A_FTOP; cw.nxt = S_LK1;
         end
         S_LK1: begin
            cw.act = ACT_FTOP_LINK; cw.nra = NRA_ANC; cw.nxt = S_LK2;
         end
         S_LK2: begin
            cw.act = ACT_N_AU; cw.vwr = 1'b1; cw.nxt = S_LK3;
         end
         S_LK3: begin
            cw.wn = WN_PUSH_A; cw.wp = WP_A_ANC; cw.nxt = S_LK4;
         end
         S_LK4: begin
            cw.wn = WN_ANC_A; cw.wp = WP_N_A; cw.act = ACT_PUSH_DONE; cw.res = RES_PUSH;
         end
         // pop entry points
         S_PAF: begin
            cw.cond = C_NOUSE; cw.jmp = S_BAD; cw.act = ACT_ANC_TGT; cw.nxt = S_UL0;
         end
         S_PBF: begin
            cw.cond = C_NOUSE; cw.jmp = S_BAD; cw.act = ACT_D_PLINK; cw.nxt = S_PBF2;
         end
         S_PBF2: begin
            cw.cond = C_DZERO; cw.jmp = S_EMPTY; cw.pra = PRA_D; cw.nxt = S_PBF3;
         end
         S_PBF3: begin
            cw.act = ACT_ANC_PLINK; cw.nxt = S_UL0;
         end
         S_PF: begin
            cw.act = ACT_ANC_ZERO; cw.nxt = S_UL0;
         end
         S_PK: begin
            cw.pra = PRA_ZERO; cw.nxt = S_PK2;
         end
         S_PK2: begin
            cw.act = ACT_D_PLINK; cw.nxt = S_PBF2;
         end
         // unlink the slot after the anchor
         S_UL0: begin
            cw.nra = NRA_ANC; cw.nxt = S_UL1;
         end
         S_UL1: begin
            cw.act = ACT_D_AU; cw.nra = NRA_LINK; cw.nxt = S_UL2;
         end
         S_UL2: begin
            cw.cond = C_POPNONE; cw.jmp = S_EMPTY;
            cw.act = ACT_N; cw.vrd = 1'b1; cw.nxt = S_UL3;
         end
         S_UL3: begin
            cw.wn = WN_ANC_N; cw.wp = WP_N_ANC; cw.nxt = S_UL4;
         end
         S_UL4: begin
            cw.wn = WN_FREE_D; cw.wp = WP_D_ZERO; cw.act = ACT_POP_DONE; cw.res = RES_POP;
         end
         // walk the forward links
         S_LOC0: begin
            cw.cond = C_TGTZERO; cw.jmp = S_LOCEND;
            cw.nra = NRA_ZERO; cw.act = ACT_D_ZERO; cw.nxt = S_LOC1;
         end
         S_LOC1: begin
            cw.cond = C_TGTNOTONE; cw.jmp = S_LOC1;
            cw.nra = NRA_LINK; cw.act = ACT_HOP; cw.nxt = S_LOCEND;
         end
         S_LOCEND: cw.res = RES_LOC;
         S_BAD:    cw.res = RES_BAD;
         S_EMPTY:  cw.res = RES_EMPTY;
         S_FULL:   cw.res = RES_FULL;
         default:  cw.res = RES_BAD;
      endcase
      return cw;
   endfunction

endpackage

// ===== src/ille_req_if.sv =====
// ----------------------------------------------------------------------------
// ille_req_if
// Request channel: valid/ready handshake carrying one list request.
// ----------------------------------------------------------------------------
interface ille_req_if;
   import ille_pkg::*;

   logic                valid;
   logic                ready;
   logic [TYPE_W-1:0]   req_type;
   logic [SLOT_W-1:0]   target_index;
   logic [VALUE_W-1:0]  value_in;

   modport source (output valid, req_type, target_index, value_in, input ready);
   modport sink   (input valid, req_type, target_index, value_in, output ready);
endinterface

// ===== src/ille_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ille_rsp_if
// Response channel: valid/ready handshake carrying one request outcome.
// ----------------------------------------------------------------------------
interface ille_rsp_if;
   import ille_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  value_out;
   logic                empty_flag;
   logic [SLOT_W-1:0]   slot_index;

   modport source (output valid, status, value_out, empty_flag, slot_index, input ready);
   modport sink   (input valid, status, value_out, empty_flag, slot_index, output ready);
endinterface

// ===== src/indexed_linked_list_engine.sv =====
// Push, pop and locate each run as a sequence of control-word steps; locate makes
// one link hop per step through the registered forward link table read.
// Rejected requests jump to a final step that reports their status. One transaction is in flight at a time;
// the next is taken the cycle after the response is registered. Each step is one
// control word, bounded by the one read and one write port of each link table.
// Reset empties the list at once via per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// indexed_linked_list_engine
// Circular doubly linked list in a slot table with a free stack, run by a
// small microprogram over a datapath of link tables and work registers.
// ----------------------------------------------------------------------------
module indexed_linked_list_engine (
   input  logic        clock,
   input  logic        reset,
   ille_req_if.sink    req_chan,
   ille_rsp_if.source  rsp_chan
);
   import ille_pkg::*;

   // sequencer and work registers
   logic                busy_ff, busy_in;
   step_type            step_ff, step_in;
   logic [SLOT_W-1:0]   tgt_ff, tgt_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic [SLOT_W-1:0]   anc_ff, anc_in;
   logic [SLOT_W-1:0]   a_ff, a_in;
   logic [SLOT_W-1:0]   n_ff, n_in;
   logic [SLOT_W-1:0]   d_ff, d_in;
   logic                au_ff, au_in;
   logic [SLOT_W-1:0]   ftop_ff, ftop_in;
   logic                fe_ff, fe_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;

   // forward link table
   link_word_type       nmem [CAPACITY];
   logic [CAPACITY-1:0] nvld_ff;
   link_word_type       nq_ff;
   logic [SLOT_W-1:0]   naddr_ff;
   logic                nqv_ff;
   logic                n_ren, n_wen;
   logic [SLOT_W-1:0]   n_raddr, n_waddr;
   link_word_type       n_wdata;
   link_word_type       nrd;

   // backward link table
   logic [SLOT_W-1:0]   pmem [CAPACITY];
   logic [CAPACITY-1:0] pvld_ff;
   logic [SLOT_W-1:0]   pq_ff;
   logic                pqv_ff;
   logic                p_ren, p_wen;
   logic [SLOT_W-1:0]   p_raddr, p_waddr, p_wdata;
   logic [SLOT_W-1:0]   prd;

   // value store
   logic [VALUE_W-1:0]  vmem [CAPACITY];
   logic [VALUE_W-1:0]  vq_ff;

   ctrl_word_type       cw;
   logic                accept, fin, blocked, go, hit;

   assign cw      = ucode(step_ff);
   assign accept  = req_chan.valid && req_chan.ready;
   assign fin     = busy_ff && (cw.res != RES_NONE);
   assign blocked = fin && rsp_valid_ff && !rsp_chan.ready;
   assign go      = busy_ff && !blocked;

   assign req_chan.ready      = !busy_ff;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.value_out  = rsp_value_ff;
   assign rsp_chan.empty_flag = rsp_empty_ff;
   assign rsp_chan.slot_index = rsp_slot_ff;

   // entries never written read as their reset contents
   assign nrd = nqv_ff ? nq_ff : link_reset(naddr_ff);
   assign prd = pqv_ff ? pq_ff : '0;

   // link table ports
   always_comb begin
      n_ren   = 1'b0;
      n_raddr = '0;
      if (accept) begin
         n_ren   = 1'b1;
         n_raddr = req_chan.target_index;
      end else if (go) begin
         n_ren = (cw.nra != NRA_NONE);
         case (cw.nra)
            NRA_ZERO: n_raddr = '0;
            NRA_FTOP: n_raddr = ftop_ff;
            NRA_ANC:  n_raddr = anc_ff;
            NRA_LINK: n_raddr = nrd.link;
            default:  n_raddr = '0;
         endcase
      end

      p_ren   = 1'b0;
      p_raddr = '0;
      if (accept) begin
         p_ren   = 1'b1;
         p_raddr = req_chan.target_index;
      end else if (go) begin
         p_ren = (cw.pra != PRA_NONE);
         case (cw.pra)
            PRA_ZERO: p_raddr = '0;
            PRA_D:    p_raddr = d_ff;
            default:  p_raddr = '0;
         endcase
      end

      n_wen   = go && (cw.wn != WN_NONE);
      n_waddr = '0;
      n_wdata = '0;
      case (cw.wn)
         WN_PUSH_A: begin
            n_waddr = a_ff;   n_wdata.used = 1'b1;  n_wdata.link = n_ff;
         end
         WN_ANC_A: begin
            n_waddr = anc_ff; n_wdata.used = au_ff; n_wdata.link = a_ff;
         end
         WN_ANC_N: begin
            n_waddr = anc_ff; n_wdata.used = au_ff; n_wdata.link = n_ff;
         end
         WN_FREE_D: begin
            n_waddr = d_ff;   n_wdata.used = 1'b0;  n_wdata.link = ftop_ff;
         end
         default: n_waddr = '0;
      endcase

      p_wen   = go && (cw.wp != WP_NONE);
      p_waddr = '0;
      p_wdata = '0;
      case (cw.wp)
         WP_A_ANC:  begin p_waddr = a_ff; p_wdata = anc_ff; end
         WP_N_A:    begin p_waddr = n_ff; p_wdata = a_ff;   end
         WP_N_ANC:  begin p_waddr = n_ff; p_wdata = anc_ff; end
         WP_D_ZERO: begin p_waddr = d_ff; p_wdata = '0;     end
         default:   p_waddr = '0;
      endcase
   end

   // jump condition
   always_comb begin
      case (cw.cond)
         C_NOUSE:     hit = !nrd.used;
         C_FULL:      hit = fe_ff;
         C_POPNONE:   hit = (d_ff == '0) || !nrd.used || (cnt_ff == '0);
         C_DZERO:     hit = (d_ff == '0);
         C_TGTZERO:   hit = (tgt_ff == '0);
         C_TGTNOTONE: hit = (tgt_ff != SLOT_W'(1));
         default:     hit = 1'b0;
      endcase
   end

   // sequencer and datapath
   always_comb begin
      busy_in       = busy_ff;
      step_in       = step_ff;
      tgt_in        = tgt_ff;
      val_in        = val_ff;
      anc_in        = anc_ff;
      a_in          = a_ff;
      n_in          = n_ff;
      d_in          = d_ff;
      au_in         = au_ff;
      ftop_in       = ftop_ff;
      fe_in         = fe_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_slot_in   = rsp_slot_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         busy_in = 1'b1;
         step_in = dispatch(req_chan.req_type);
         tgt_in  = req_chan.target_index;
         val_in  = req_chan.value_in;
      end

      if (go) begin
         case (cw.act)
            ACT_ANC_TGT:   anc_in = tgt_ff;
            ACT_ANC_ZERO:  anc_in = '0;
            ACT_ANC_PLINK: anc_in = prd;
            ACT_A_FTOP:    a_in = ftop_ff;
            ACT_FTOP_LINK: ftop_in = nrd.link;
            ACT_N_AU: begin
               n_in  = nrd.link;
               au_in = nrd.used;
            end
            ACT_D_AU: begin
               d_in  = nrd.link;
               au_in = nrd.used;
            end
            ACT_N:         n_in = nrd.link;
            ACT_D_ZERO:    d_in = '0;
            ACT_D_PLINK:   d_in = prd;
            ACT_HOP: begin
               d_in   = nrd.link;
               tgt_in = tgt_ff - SLOT_W'(1);
            end
            ACT_PUSH_DONE: begin
               cnt_in = cnt_ff + COUNT_W'(1);
               fe_in  = (cnt_ff >= COUNT_W'(CAPACITY - 2));
            end
            ACT_POP_DONE: begin
               cnt_in  = cnt_ff - COUNT_W'(1);
               fe_in   = 1'b0;
               ftop_in = d_ff;
            end
            default: cnt_in = cnt_ff;
         endcase

         if (fin) begin
            busy_in       = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_value_in  = '0;
            rsp_empty_in  = 1'b0;
            rsp_slot_in   = '0;
            case (cw.res)
               RES_BAD:   rsp_status_in = ST_BAD;
               RES_FULL:  rsp_status_in = ST_FULL;
               RES_EMPTY: begin
                  rsp_status_in = ST_EMPTY;
                  rsp_empty_in  = 1'b1;
               end
               RES_PUSH:  rsp_slot_in = a_ff;
               RES_POP: begin
                  rsp_value_in = vq_ff;
                  rsp_slot_in  = d_ff;
               end
               RES_LOC:   rsp_slot_in = d_ff;
               default:   rsp_status_in = ST_BAD;
            endcase
         end else begin
            step_in = hit ? cw.jmp : cw.nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= S_BAD;
         ftop_ff      <= SLOT_W'(1);
         fe_ff        <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         nvld_ff      <= '0;
         pvld_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         ftop_ff      <= ftop_in;
         fe_ff        <= fe_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (n_wen) begin
            nvld_ff[n_waddr] <= 1'b1;
         end
         if (p_wen) begin
            pvld_ff[p_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff        <= tgt_in;
      val_ff        <= val_in;
      anc_ff        <= anc_in;
      a_ff          <= a_in;
      n_ff          <= n_in;
      d_ff          <= d_in;
      au_ff         <= au_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // forward link table: one write, one registered read
   always_ff @(posedge clock) begin
      if (n_wen) begin
         nmem[n_waddr] <= n_wdata;
      end
      if (n_ren) begin
         nq_ff    <= nmem[n_raddr];
         naddr_ff <= n_raddr;
         nqv_ff   <= nvld_ff[n_raddr];
      end
   end

   // backward link table
   always_ff @(posedge clock) begin
      if (p_wen) begin
         pmem[p_waddr] <= p_wdata;
      end
      if (p_ren) begin
         pq_ff  <= pmem[p_raddr];
         pqv_ff <= pvld_ff[p_raddr];
      end
   end

   // value store
   always_ff @(posedge clock) begin
      if (go && cw.vwr) begin
         vmem[a_ff] <= val_ff;
      end
      if (go && cw.vrd) begin
         vq_ff <= vmem[d_ff];
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= COUNT_W'(CAPACITY - 1))
      else $error("entry count beyond table capacity");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      fe_ff == (cnt_ff >= COUNT_W'(CAPACITY - 1)))
      else $error("free stack empty flag disagrees with entry count");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("accepted transaction did not start the sequencer");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      blocked |=> busy_ff && (step_ff == $past(step_ff)) && (cnt_ff == $past(cnt_ff)))
      else $error("final step advanced while the response register was full");

endmodule
